@@ sv/dmrf_pkg.sv @@
// ----------------------------------------------------------------------------
// DMR burst framer package
// Shared types, burst codes and CRC helpers for the encrypted data burst
// framer.
// ----------------------------------------------------------------------------
package dmrf_pkg;

  // Polynomials and masks of the two checksums.
  localparam logic [15:0] CRC16_POLY = 16'h1021;
  localparam logic [31:0] CRC32_POLY = 32'h04C1_1DB7;
  localparam logic [15:0] CRC16_XOROUT = 16'hFFFF;
  localparam logic [15:0] CSBK_MASK = 16'hA5A5;
  localparam logic [15:0] HDR_MASK = 16'hCCCC;

  // Burst type bytes.
  localparam logic [7:0] BURST_TYPE_CSBK = 8'h30;
  localparam logic [7:0] BURST_TYPE_HDR = 8'h60;
  localparam logic [7:0] BURST_TYPE_DATA = 8'h70;

  // Positions of the bursts within one sequence.
  localparam int unsigned IDX_W = 4;
  localparam logic [IDX_W-1:0] IDX_CSBK_FIRST = 4'd0;
  localparam logic [IDX_W-1:0] IDX_CSBK_LAST = 4'd5;
  localparam logic [IDX_W-1:0] IDX_DATA_HDR = 4'd6;
  localparam logic [IDX_W-1:0] IDX_ENC_HDR = 4'd7;
  localparam logic [IDX_W-1:0] IDX_DATA_BLK0 = 4'd8;
  localparam logic [IDX_W-1:0] IDX_DATA_BLK1 = 4'd9;
  localparam logic [7:0] CSBK_COUNT_TOP = 8'd9;

  // Checksum engine schedule: one 16-bit word per step, ten steps.
  localparam logic [IDX_W-1:0] STEP_LAST = 4'd9;
  localparam logic [IDX_W-1:0] STEP_ID_DONE = 4'd2;
  localparam logic [IDX_W-1:0] STEP_HDR_DONE = 4'd3;

  typedef struct packed {
    logic [23:0] dst_id;
    logic [23:0] src_id;
    logic [7:0]  key_id;
    logic [63:0] cipher_hi;
    logic [63:0] cipher_lo;
  } dmrf_in_t;

  typedef struct packed {
    logic [7:0]       burst_type;
    logic [47:0]      payload_hi;
    logic [47:0]      payload_lo;
    logic [IDX_W-1:0] burst_index;
    logic             last;
  } dmrf_out_t;

  // Item plus checksum partials, passed from the engine to the emitter.
  typedef struct packed {
    logic [23:0] dst_id;
    logic [23:0] src_id;
    logic [7:0]  key_id;
    logic [63:0] cipher_hi;
    logic [63:0] cipher_lo;
    logic [15:0] id_crc;
    logic [15:0] hdr_crc;
    logic [15:0] key_crc;
    logic [31:0] pdu_crc;
  } dmrf_hand_t;

  // CCITT CRC over one 16-bit word, MSB first, no final inversion.
  function automatic logic [15:0] crc16_step16(input logic [15:0] crc,
                                               input logic [15:0] word);
    logic [15:0] c;
    c = crc;
    for (int k = 15; k >= 0; k--) begin
      if (c[15] ^ word[k]) begin
        c = {c[14:0], 1'b0} ^ CRC16_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  // CRC32 over one 16-bit word, MSB first, no final inversion.
  function automatic logic [31:0] crc32_step16(input logic [31:0] crc,
                                               input logic [15:0] word);
    logic [31:0] c;
    c = crc;
    for (int k = 15; k >= 0; k--) begin
      if (c[31] ^ word[k]) begin
        c = {c[30:0], 1'b0} ^ CRC32_POLY;
      end else begin
        c = {c[30:0], 1'b0};
      end
    end
    return c;
  endfunction

  // Raw CRC16 of a ten-byte header body; used for elaboration constants.
  function automatic logic [15:0] crc16_body(input logic [79:0] body);
    logic [15:0] c;
    c = 16'h0000;
    for (int w = 4; w >= 0; w--) begin
      c = crc16_step16(c, body[w*16 +: 16]);
    end
    return c;
  endfunction

  // Fixed part of a CSBK checksum for a given countdown value, inversion
  // and mask folded in.
  function automatic logic [15:0] csbk_base(input logic [7:0] count);
    return crc16_body({8'hBD, 8'h00, 8'h80, count, 48'h0}) ^ CRC16_XOROUT ^ CSBK_MASK;
  endfunction

  // Entry i belongs to CSBK burst i, whose countdown byte is 9 - i.
  localparam logic [5:0][15:0] CSBK_CRC_BASE = {
    csbk_base(8'd4), csbk_base(8'd5), csbk_base(8'd6),
    csbk_base(8'd7), csbk_base(8'd8), csbk_base(8'd9)
  };

  localparam logic [15:0] HDR_CRC_BASE =
    crc16_body({8'h02, 8'h94, 48'h0, 8'h83, 8'h00}) ^ CRC16_XOROUT ^ HDR_MASK;

  localparam logic [15:0] ENC_CRC_BASE =
    crc16_body({8'h4F, 8'h10, 8'h51, 8'h00, 48'h0}) ^ CRC16_XOROUT ^ HDR_MASK;

endpackage

@@ sv/dmrf_crc_engine.sv @@
// ----------------------------------------------------------------------------
// DMR burst framer checksum engine
// Holds one item and works out its header CRC partials and PDU CRC32,
// one 16-bit word per cycle.
// ----------------------------------------------------------------------------
module dmrf_crc_engine
  import dmrf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dmrf_in_t   in_data_i,
  output logic       hand_valid_o,
  input  logic       hand_ready_i,
  output dmrf_hand_t hand_o
);

  logic             busy_q;
  logic [IDX_W-1:0] step_q;
  dmrf_in_t         item_q;
  logic [15:0]      id_crc_q, id_crc_d;
  logic [15:0]      id_save_q;
  logic [15:0]      key_crc_q, key_crc_d;
  logic [31:0]      pdu_crc_q, pdu_crc_d;
  logic [127:0]     cipher;
  logic [15:0]      cipher_pair;
  logic [15:0]      pdu_word;
  logic [15:0]      id_word;
  logic [15:0]      key_word;
  logic             in_fire;
  logic             hand_fire;
  logic             step_en;

  assign hand_valid_o = busy_q && (step_q == STEP_LAST);
  assign hand_fire    = hand_valid_o && hand_ready_i;
  assign in_ready_o   = !busy_q || hand_fire;
  assign in_fire      = in_valid_i && in_ready_o;
  assign step_en      = busy_q && (step_q != STEP_LAST);

  // The PDU is read in swapped byte pairs; the pad bytes fill the last two steps.
  assign cipher      = {item_q.cipher_hi, item_q.cipher_lo};
  assign cipher_pair = cipher[{~step_q[2:0], 4'b0000} +: 16];
  assign pdu_word    = step_q[3] ? 16'h0000 : {cipher_pair[7:0], cipher_pair[15:8]};

  always_comb begin
    case (step_q)
      4'd0:    id_word = item_q.dst_id[23:8];
      4'd1:    id_word = {item_q.dst_id[7:0], item_q.src_id[23:16]};
      4'd2:    id_word = item_q.src_id[15:0];
      default: id_word = 16'h0000;
    endcase
  end

  assign key_word = (step_q == 4'd0) ? {8'h00, item_q.key_id} : 16'h0000;

  always_comb begin
    pdu_crc_d = crc32_step16(pdu_crc_q, pdu_word);
    id_crc_d  = id_crc_q;
    key_crc_d = key_crc_q;
    if (step_q <= STEP_HDR_DONE) begin
      id_crc_d  = crc16_step16(id_crc_q, id_word);
      key_crc_d = crc16_step16(key_crc_q, key_word);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (in_fire) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (hand_fire) begin
      busy_q <= 1'b0;
    end else if (step_en) begin
      step_q <= step_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q    <= in_data_i;
      id_crc_q  <= '0;
      key_crc_q <= '0;
      pdu_crc_q <= '0;
    end else if (step_en) begin
      id_crc_q  <= id_crc_d;
      key_crc_q <= key_crc_d;
      pdu_crc_q <= pdu_crc_d;
      if (step_q == STEP_ID_DONE) begin
        id_save_q <= id_crc_d;
      end
    end
  end

  // The final CRC32 word is folded in on the way out.
  assign hand_o = '{
    dst_id:    item_q.dst_id,
    src_id:    item_q.src_id,
    key_id:    item_q.key_id,
    cipher_hi: item_q.cipher_hi,
    cipher_lo: item_q.cipher_lo,
    id_crc:    id_save_q,
    hdr_crc:   id_crc_q,
    key_crc:   key_crc_q,
    pdu_crc:   pdu_crc_d
  };

endmodule

@@ sv/dmrf_burst_emitter.sv @@
// ----------------------------------------------------------------------------
// DMR burst framer emitter
// Builds an item's ten bursts into out_q, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module dmrf_burst_emitter
  import dmrf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       hand_valid_i,
  output logic       hand_ready_o,
  input  dmrf_hand_t hand_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output dmrf_out_t  out_data_o
);

  logic             em_valid_q;
  logic [IDX_W-1:0] em_cnt_q;
  dmrf_hand_t       em_q;
  logic             out_valid_q;
  dmrf_out_t        out_q;
  dmrf_out_t        burst;
  logic [95:0]      payload;
  logic [31:0]      crc_rev;
  logic             out_load;
  logic             em_done;
  logic             hand_fire;

  assign out_load     = em_valid_q && (!out_valid_q || out_ready_i);
  assign em_done      = out_load && (em_cnt_q == IDX_DATA_BLK1);
  assign hand_ready_o = !em_valid_q || em_done;
  assign hand_fire    = hand_valid_i && hand_ready_o;

  // The CRC32 is stored with its bytes reversed.
  assign crc_rev = {em_q.pdu_crc[7:0], em_q.pdu_crc[15:8],
                    em_q.pdu_crc[23:16], em_q.pdu_crc[31:24]};

  always_comb begin
    case (em_cnt_q) inside
      [IDX_CSBK_FIRST:IDX_CSBK_LAST]: begin
        burst.burst_type = BURST_TYPE_CSBK;
        payload = {8'hBD, 8'h00, 8'h80, CSBK_COUNT_TOP - {4'h0, em_cnt_q},
                   em_q.dst_id, em_q.src_id,
                   CSBK_CRC_BASE[em_cnt_q[2:0]] ^ em_q.id_crc};
      end
      IDX_DATA_HDR: begin
        burst.burst_type = BURST_TYPE_HDR;
        payload = {8'h02, 8'h94, em_q.dst_id, em_q.src_id, 8'h83, 8'h00,
                   HDR_CRC_BASE ^ em_q.hdr_crc};
      end
      IDX_ENC_HDR: begin
        burst.burst_type = BURST_TYPE_HDR;
        payload = {8'h4F, 8'h10, 8'h51, em_q.key_id, 48'h0,
                   ENC_CRC_BASE ^ em_q.key_crc};
      end
      IDX_DATA_BLK0: begin
        burst.burst_type = BURST_TYPE_DATA;
        payload = {em_q.cipher_hi, em_q.cipher_lo[63:32]};
      end
      default: begin
        burst.burst_type = BURST_TYPE_DATA;
        payload = {em_q.cipher_lo[31:0], 32'h0, crc_rev};
      end
    endcase
    burst.payload_hi  = payload[95:48];
    burst.payload_lo  = payload[47:0];
    burst.burst_index = em_cnt_q;
    burst.last        = (em_cnt_q == IDX_DATA_BLK1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      em_valid_q  <= 1'b0;
      em_cnt_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (hand_fire) begin
        em_valid_q <= 1'b1;
        em_cnt_q   <= IDX_CSBK_FIRST;
      end else if (em_done) begin
        em_valid_q <= 1'b0;
      end else if (out_load) begin
        em_cnt_q <= em_cnt_q + 4'd1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (hand_fire) begin
      em_q <= hand_i;
    end
    if (out_load) begin
      out_q <= burst;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ sv/dmr_encrypted_data_burst_framer.sv @@
// ----------------------------------------------------------------------------
// DMR encrypted data burst framer
// Frames one ciphertext block into six CSBK preambles, a data header, an
// encryption header and two data blocks.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid_i/in_ready_o  in_data_i  (ids, key, ciphertext)
//   out      output     out_valid_o/out_ready_i out_data_o (type, payload, index)
//
// Each input transfer yields ten output transfers. The engine folds one 16-bit
// CRC word per cycle and the emitter builds one burst per cycle while the
// output is not stalled, each on its own item, side by side; the engine takes
// a new item as it hands its last one to the emitter.
// Reset clears only the control state. An output stall backs up through the
// emitter into the engine, which refuses input until it has handed its item on.
// ----------------------------------------------------------------------------
module dmr_encrypted_data_burst_framer
  import dmrf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  dmrf_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output dmrf_out_t out_data_o
);

  // Handoff between the two stages: the item plus its finished checksum
  // partials. The header checksums are linear, so the engine only keeps the
  // parts that depend on the IDs and the key; the emitter adds fixed parts.
  logic       hand_valid;
  logic       hand_ready;
  dmrf_hand_t hand;

  // First stage: registers the item and runs the CRC16 and CRC32 words.
  dmrf_crc_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .hand_valid_o (hand_valid),
    .hand_ready_i (hand_ready),
    .hand_o       (hand)
  );

  // Second stage: walks the burst index and loads the output register, so
  // the next item's checksums are already running while bursts drain.
  dmrf_burst_emitter u_emitter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .hand_valid_i (hand_valid),
    .hand_ready_o (hand_ready),
    .hand_i       (hand),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

  // The last flag marks exactly the final burst of a sequence.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.last == (out_data_o.burst_index == IDX_DATA_BLK1)))
    else $error("last flag does not match burst index");

  // Preamble positions always carry the CSBK type.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.burst_index <= IDX_CSBK_LAST))
      |-> (out_data_o.burst_type == BURST_TYPE_CSBK))
    else $error("CSBK position carries a wrong burst type");

  // Within a sequence the next burst is ready right after a transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !out_data_o.last) |=> out_valid_o)
    else $error("gap inside a burst sequence");

  // Consecutive bursts of a sequence come in index order.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !out_data_o.last)
      |=> (out_data_o.burst_index == $past(out_data_o.burst_index) + 4'd1))
    else $error("burst index out of order");

endmodule
